### rtl/mact_pkg.sv
// Package for the moving average crossover trade engine.
// Holds field widths, register indexes, reset values, the signal codes and the
// sequencer state type. It depends on nothing.
package mact_pkg;

    localparam int PRICE_W    = 32;
    localparam int WIN_W      = 9;
    localparam int CASH_W     = 56;
    localparam int SHARE_W    = 40;
    localparam int SHARE_HALF = SHARE_W / 2;
    localparam int SIG_W      = 2;
    localparam int CFG_IDX_W  = 2;

    // Quotient bits the divider resolves per clock.
    localparam int DIV_BITS_PER_CYCLE = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_CASH = 2'd2;

    localparam logic [WIN_W-1:0]  RST_SHORT_WINDOW = 9'd20;
    localparam logic [WIN_W-1:0]  RST_LONG_WINDOW  = 9'd50;
    localparam logic [CASH_W-1:0] RST_INITIAL_CASH = 56'd2560000;

    localparam logic [CASH_W-1:0]  CASH_MAX  = {CASH_W{1'b1}};
    localparam logic [SHARE_W-1:0] SHARE_MAX = {SHARE_W{1'b1}};

    typedef enum logic [SIG_W-1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } sig_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_S,
        S_UPD_S,
        S_UPD_L,
        S_WR,
        S_PASS_RD,
        S_PASS_ACC,
        S_MUL,
        S_CMP,
        S_DIV,
        S_PM_LO,
        S_PM_HI,
        S_FIN
    } state_t;

endpackage

### rtl/mact_div.sv
// Iterative unsigned divider for the trade engine: cash by price, two
// quotient bits per clock, restoring form.
// Depends on mact_pkg for the cash and price widths.
module mact_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mact_pkg::CASH_W-1:0]  dividend,
    input  logic [mact_pkg::PRICE_W-1:0] divisor,
    output logic                         done,
    output logic [mact_pkg::CASH_W-1:0]  quotient
);
    import mact_pkg::*;

    localparam int STEPS = CASH_W / DIV_BITS_PER_CYCLE;
    localparam int CNT_W = $clog2(STEPS);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PRICE_W-1:0]  rem_reg;
    logic [CASH_W-1:0]   dq_reg;
    logic [PRICE_W-1:0]  den_reg;
    logic [PRICE_W-1:0]  rem_step;
    logic [CASH_W-1:0]   dq_step;
    logic                last_step;

    assign last_step = busy_reg && (cnt_reg == CNT_W'(STEPS - 1));

    // The dividend shifts out of the top of dq while quotient bits shift in.
    always_comb
    begin : div_step
        logic [PRICE_W:0] trial;
        rem_step = rem_reg;
        dq_step  = dq_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            trial = {rem_step, dq_step[CASH_W-1]};
            if (trial >= {1'b0, den_reg})
            begin
                trial   = trial - {1'b0, den_reg};
                dq_step = {dq_step[CASH_W-2:0], 1'b1};
            end
            else
            begin
                dq_step = {dq_step[CASH_W-2:0], 1'b0};
            end
            rem_step = trial[PRICE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (last_step)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            den_reg <= divisor;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            dq_reg  <= dq_step;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

### rtl/ma_crossover_trade_engine.sv
// Top level of the moving average crossover trade engine.
// Depends on mact_pkg and instantiates the divider mact_div.
//
// Each input word carries one closing price (unsigned Q24.8) and a restart
// flag; each one yields exactly one result word with the trade signal, the
// shares held and the portfolio value (Q48.8, saturating). Prices are kept in
// a ring memory of MAX_WINDOW entries with one registered read port, and the
// short and long window sums are kept as running sums that add the new price
// and subtract the price that leaves each window. The block works on one
// word at a time. A hold or sell passes through the two ring reads with their
// sum updates, the ring write, the compare multipliers, the compare and a
// shares-times-price product split into two 20-by-32 halves before its
// result is loaded; the sequencer then returns to idle and takes the next
// word. A buy adds the divider, which resolves two quotient bits per cycle,
// between the compare and the product. After a write to either window
// length, the next word that does not restart skips the running update and
// rebuilds both sums from the ring after the write, reading and adding one
// entry at a time. A finished result waits in the last step while the output
// register still holds a word that has not been taken. The next input word
// is taken while a result still waits in the output register. Configuration
// must be written only while the block is idle; the block itself does not
// enforce this. A new initial cash takes effect at the next restart.
module ma_crossover_trade_engine #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mact_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mact_pkg::CASH_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mact_pkg::PRICE_W-1:0]   price,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mact_pkg::SIG_W-1:0]     signal,
    output logic [mact_pkg::SHARE_W-1:0]   shares_held,
    output logic [mact_pkg::CASH_W-1:0]    portfolio_value
);
    import mact_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (WW > WIN_W) ? WW : WIN_W;
    localparam int XW = WW + 1;
    localparam int SW = PRICE_W + AW;
    localparam int LW = SW + WW;
    localparam int HPW = SHARE_HALF + PRICE_W;
    localparam int PW = SHARE_W + PRICE_W;

    // Sequencer.
    state_t state_reg;
    state_t state_next;

    // Configuration.
    logic [WIN_W-1:0]  short_window_reg;
    logic [WIN_W-1:0]  long_window_reg;
    logic [CASH_W-1:0] initial_cash_reg;

    // Strategy state.
    logic [WW-1:0]      filled_count_reg;
    logic [AW-1:0]      write_position_reg;
    logic [SW-1:0]      short_sum_reg;
    logic [SW-1:0]      long_sum_reg;
    logic [CASH_W-1:0]  cash_held_reg;
    logic [SHARE_W-1:0] share_count_reg;
    logic               resum_reg;
    logic               pass_reg;

    // Working registers.
    logic [PRICE_W-1:0] price_reg;
    logic [WW-1:0]      pass_cnt_reg;
    logic [LW-1:0]      lhs_reg;
    logic [LW-1:0]      rhs_reg;
    sig_t               sig_reg;
    logic [HPW-1:0]     plo_reg;
    logic [HPW-1:0]     phi_reg;

    // Output register.
    logic               out_valid_reg;
    sig_t               out_sig_reg;
    logic [SHARE_W-1:0] out_shares_reg;
    logic [CASH_W-1:0]  out_value_reg;

    // Price ring.
    logic [PRICE_W-1:0] ring_mem [MAX_WINDOW];
    logic [PRICE_W-1:0] rd_data_reg;

    // Control.
    logic               accept;
    logic               mem_rd;
    logic               mem_wr;
    logic [AW-1:0]      rd_addr;
    logic               div_start;
    logic               div_done;
    logic [CASH_W-1:0]  div_quot;
    logic               out_free;
    logic               out_load;

    // Derived values.
    logic [WW-1:0]      ws;
    logic [WW-1:0]      wl;
    logic [WW-1:0]      max_w;
    logic [WW-1:0]      pass_len;
    logic [AW-1:0]      drop_s_addr;
    logic [AW-1:0]      drop_l_addr;
    logic [AW-1:0]      newest_addr;
    logic               drop_s;
    logic               drop_l;
    logic [SW-1:0]      short_eff;
    logic [SW-1:0]      long_eff;
    logic               buy_want;
    logic               buy_go;
    logic               sell_go;
    logic [SHARE_W-1:0] quot_sat;
    logic [PW-1:0]      p_full;
    logic [CASH_W-1:0]  p_sat;
    logic [CASH_W:0]    value_sum;
    logic [CASH_W-1:0]  value_hold;
    logic [CASH_W-1:0]  value_out;
    logic [SHARE_W-1:0] shares_out;

    // A window of zero acts as one, and a window past the ring acts as the ring.
    function automatic logic [WW-1:0] clamp_win(input logic [WIN_W-1:0] w);
        logic [CW-1:0] ext;
        ext = CW'(w);
        if (w == '0)
            return WW'(1);
        else if (ext > CW'(MAX_WINDOW))
            return WW'(MAX_WINDOW);
        else
            return ext[WW-1:0];
    endfunction

    // Ring slot that lies offset places behind pos, wrapping at the ring size.
    function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] pos,
                                                input logic [XW-1:0] offset);
        logic [XW-1:0] a;
        a = XW'(pos);
        if (a >= offset)
            return AW'(a - offset);
        else
            return AW'(a + XW'(MAX_WINDOW) - offset);
    endfunction

    assign ws       = clamp_win(short_window_reg);
    assign wl       = clamp_win(long_window_reg);
    assign max_w    = (ws > wl) ? ws : wl;
    assign pass_len = (filled_count_reg < max_w) ? filled_count_reg : max_w;

    // Before the ring write, the price leaving a full window sits exactly
    // one window length behind the write position.
    assign drop_s_addr = ring_back(write_position_reg, XW'(ws));
    assign drop_l_addr = ring_back(write_position_reg, XW'(wl));
    assign newest_addr = ring_back(write_position_reg, XW'(pass_cnt_reg) + XW'(1));
    assign drop_s      = filled_count_reg >= ws;
    assign drop_l      = filled_count_reg >= wl;

    // A mean counts as zero until its window has filled.
    assign short_eff = (filled_count_reg >= ws) ? short_sum_reg : '0;
    assign long_eff  = (filled_count_reg >= wl) ? long_sum_reg : '0;

    assign buy_want = (lhs_reg > rhs_reg) && (share_count_reg == '0);
    assign buy_go   = buy_want && (price_reg != '0);
    assign sell_go  = !buy_want && (lhs_reg < rhs_reg) && (share_count_reg != '0);

    assign quot_sat = (div_quot[CASH_W-1:SHARE_W] != '0) ? SHARE_MAX
                                                          : div_quot[SHARE_W-1:0];

    // Shares times price from the two partial products, then saturation.
    assign p_full     = (PW'(phi_reg) << SHARE_HALF) + PW'(plo_reg);
    assign p_sat      = (p_full[PW-1:CASH_W] != '0) ? CASH_MAX : p_full[CASH_W-1:0];
    assign value_sum  = {1'b0, cash_held_reg} + {1'b0, p_sat};
    assign value_hold = value_sum[CASH_W] ? CASH_MAX : value_sum[CASH_W-1:0];
    assign value_out  = (sig_reg == SIG_SELL) ? p_sat : value_hold;
    assign shares_out = (sig_reg == SIG_SELL) ? '0 : share_count_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (resum_reg && !restart)
                        state_next = S_WR;
                    else
                        state_next = S_RD_S;
                end
            end
            S_RD_S:     state_next = S_UPD_S;
            S_UPD_S:    state_next = S_UPD_L;
            S_UPD_L:    state_next = S_WR;
            S_WR:       state_next = pass_reg ? S_PASS_RD : S_MUL;
            S_PASS_RD:  state_next = S_PASS_ACC;
            S_PASS_ACC:
            begin
                if (pass_cnt_reg + WW'(1) == pass_len)
                    state_next = S_MUL;
                else
                    state_next = S_PASS_RD;
            end
            S_MUL:      state_next = S_CMP;
            S_CMP:      state_next = buy_go ? S_DIV : S_PM_LO;
            S_DIV:      state_next = div_done ? S_PM_LO : S_DIV;
            S_PM_LO:    state_next = S_PM_HI;
            S_PM_HI:    state_next = S_FIN;
            S_FIN:      state_next = out_free ? S_IDLE : S_FIN;
            default:    state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready  = 1'b0;
        mem_rd    = 1'b0;
        mem_wr    = 1'b0;
        rd_addr   = newest_addr;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_RD_S:
            begin
                mem_rd  = 1'b1;
                rd_addr = drop_s_addr;
            end
            S_UPD_S:
            begin
                mem_rd  = 1'b1;
                rd_addr = drop_l_addr;
            end
            S_WR:
            begin
                mem_wr = 1'b1;
            end
            S_PASS_RD:
            begin
                mem_rd = 1'b1;
            end
            S_CMP:
            begin
                div_start = buy_go;
            end
            S_FIN:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Ring memory: one write and one registered read per cycle. Reads of the
    // leaving prices happen before the write of the same item, so the slot
    // that a full ring overwrites is read while it still holds its old price.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            ring_mem[write_position_reg] <= price_reg;
        if (mem_rd)
            rd_data_reg <= ring_mem[rd_addr];
    end

    mact_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cash_held_reg),
        .divisor  (price_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Control and strategy state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            short_window_reg   <= RST_SHORT_WINDOW;
            long_window_reg    <= RST_LONG_WINDOW;
            initial_cash_reg   <= RST_INITIAL_CASH;
            filled_count_reg   <= '0;
            write_position_reg <= '0;
            short_sum_reg      <= '0;
            long_sum_reg       <= '0;
            cash_held_reg      <= RST_INITIAL_CASH;
            share_count_reg    <= '0;
            resum_reg          <= 1'b0;
            pass_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                // The first word after a window change rebuilds both sums,
                // unless it restarts and so empties them anyway.
                pass_reg  <= resum_reg && !restart;
                resum_reg <= 1'b0;
                if (restart)
                begin
                    filled_count_reg   <= '0;
                    write_position_reg <= '0;
                    short_sum_reg      <= '0;
                    long_sum_reg       <= '0;
                    cash_held_reg      <= initial_cash_reg;
                    share_count_reg    <= '0;
                end
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_SHORT_WINDOW:
                    begin
                        short_window_reg <= cfg_data[WIN_W-1:0];
                        resum_reg        <= 1'b1;
                    end
                    REG_LONG_WINDOW:
                    begin
                        long_window_reg <= cfg_data[WIN_W-1:0];
                        resum_reg       <= 1'b1;
                    end
                    REG_INITIAL_CASH:
                    begin
                        initial_cash_reg <= cfg_data;
                    end
                    default:
                    begin
                        resum_reg <= resum_reg;
                    end
                endcase
            end

            if (state_reg == S_UPD_S)
                short_sum_reg <= short_sum_reg + SW'(price_reg)
                                 - (drop_s ? SW'(rd_data_reg) : '0);

            if (state_reg == S_UPD_L)
                long_sum_reg <= long_sum_reg + SW'(price_reg)
                                - (drop_l ? SW'(rd_data_reg) : '0);

            if (state_reg == S_WR)
            begin
                write_position_reg <= (write_position_reg == AW'(MAX_WINDOW - 1))
                                      ? '0 : write_position_reg + AW'(1);
                if (filled_count_reg != WW'(MAX_WINDOW))
                    filled_count_reg <= filled_count_reg + WW'(1);
                if (pass_reg)
                begin
                    short_sum_reg <= '0;
                    long_sum_reg  <= '0;
                end
            end

            // Rebuild pass: entry k back from the newest belongs to every
            // window longer than k.
            if (state_reg == S_PASS_ACC)
            begin
                if (pass_cnt_reg < ws)
                    short_sum_reg <= short_sum_reg + SW'(rd_data_reg);
                if (pass_cnt_reg < wl)
                    long_sum_reg <= long_sum_reg + SW'(rd_data_reg);
            end

            // Buy: all cash goes into whole shares; the remainder is dropped.
            if ((state_reg == S_DIV) && div_done)
            begin
                share_count_reg <= quot_sat;
                cash_held_reg   <= '0;
            end

            if (out_load && (sig_reg == SIG_SELL))
            begin
                cash_held_reg   <= p_sat;
                share_count_reg <= '0;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers and result word.
    always_ff @(posedge clk)
    begin
        if (accept)
            price_reg <= price;

        if (state_reg == S_WR)
            pass_cnt_reg <= '0;
        else if (state_reg == S_PASS_ACC)
            pass_cnt_reg <= pass_cnt_reg + WW'(1);

        // Exact mean compare: short_sum * long_window against long_sum * short_window.
        if (state_reg == S_MUL)
        begin
            lhs_reg <= LW'(short_eff) * LW'(wl);
            rhs_reg <= LW'(long_eff) * LW'(ws);
        end

        if (state_reg == S_CMP)
        begin
            if (buy_go)
                sig_reg <= SIG_BUY;
            else if (sell_go)
                sig_reg <= SIG_SELL;
            else
                sig_reg <= SIG_HOLD;
        end

        if (state_reg == S_PM_LO)
            plo_reg <= HPW'(share_count_reg[SHARE_HALF-1:0]) * HPW'(price_reg);

        if (state_reg == S_PM_HI)
            phi_reg <= HPW'(share_count_reg[SHARE_W-1:SHARE_HALF]) * HPW'(price_reg);

        if (out_load)
        begin
            out_sig_reg    <= sig_reg;
            out_shares_reg <= shares_out;
            out_value_reg  <= value_out;
        end
    end

    assign out_valid       = out_valid_reg;
    assign signal          = out_sig_reg;
    assign shares_held     = out_shares_reg;
    assign portfolio_value = out_value_reg;

    // The fill count saturates at the ring size.
    assert property (@(posedge clk) disable iff (!rst_n)
        filled_count_reg <= WW'(MAX_WINDOW))
        else $error("fill count beyond ring size");

    // The write position stays inside the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        XW'(write_position_reg) < XW'(MAX_WINDOW))
        else $error("write position outside ring");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside a buy");

    // A sell leaves no shares behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (sig_reg == SIG_SELL)) |=> (share_count_reg == '0))
        else $error("shares left after a sell");

    // A buy spends all cash.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (sig_reg == SIG_BUY)) |=> (cash_held_reg == '0))
        else $error("cash left after a buy");

endmodule
